// ===== rtl/core/vsfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsfp_pkg
// Shared types and constants for the vital sign frame parser.
// ----------------------------------------------------------------------------
package vsfp_pkg;

  localparam logic [63:0] SYNC_RESET   = 64'h0708050603040102;
  localparam logic [5:0]  MOTION_FIELD = 6'd33;
  localparam logic [5:0]  LAST_FIELD   = 6'd45;

  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] value;
    logic        half;
  } field_req_t;

  function automatic logic is_half_field(input logic [5:0] idx);
    is_half_field = (idx == 6'd10) || (idx == 6'd11) ||
                    (idx == 6'd14) || (idx == 6'd15);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vsfp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsfp_front
// Byte intake: magic word hunt, field assembly, completed field requests.
// ----------------------------------------------------------------------------
module vsfp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               q_full,
  output logic                    q_push,
  output vsfp_pkg::field_req_t    q_req
);

  logic [63:0] sync_pattern;
  logic [55:0] sync_window;
  logic [55:0] sync_window_next;
  logic        locked;
  logic        locked_next;
  logic [5:0]  current_field;
  logic [5:0]  current_field_next;
  logic [1:0]  byte_in_field;
  logic [1:0]  byte_in_field_next;
  logic [23:0] partial_value;
  logic [23:0] partial_value_next;

  logic        accept;
  logic        half;
  logic        last_byte;
  logic [63:0] full_window;
  logic [31:0] shifted;
  logic [31:0] value;

  assign in_stall    = q_full;
  assign accept      = in_valid && !in_stall;
  assign half        = vsfp_pkg::is_half_field(current_field);
  assign last_byte   = half ? (byte_in_field == 2'd1) : (byte_in_field == 2'd3);
  assign full_window = {rx_byte, sync_window};
  assign shifted     = {24'd0, rx_byte} << {byte_in_field, 3'b000};
  assign value       = half ? (({8'd0, partial_value} | shifted) & 32'h0000_FFFF)
                            : ({8'd0, partial_value} | shifted);

  always_comb begin
    sync_window_next   = sync_window;
    locked_next        = locked;
    current_field_next = current_field;
    byte_in_field_next = byte_in_field;
    partial_value_next = partial_value;
    q_push             = 1'b0;
    q_req.index        = current_field;
    q_req.value        = value;
    q_req.half         = half;
    if (accept) begin
      if (!locked) begin
        if (full_window == sync_pattern) begin
          locked_next        = 1'b1;
          sync_window_next   = '0;
          current_field_next = '0;
          byte_in_field_next = '0;
          partial_value_next = '0;
        end else begin
          sync_window_next = full_window[63:8];
        end
      end else if (!last_byte) begin
        partial_value_next = partial_value | shifted[23:0];
        byte_in_field_next = byte_in_field + 2'd1;
      end else begin
        q_push             = 1'b1;
        partial_value_next = '0;
        byte_in_field_next = '0;
        if (current_field >= vsfp_pkg::LAST_FIELD) begin
          locked_next        = 1'b0;
          current_field_next = '0;
        end else begin
          current_field_next = current_field + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern  <= vsfp_pkg::SYNC_RESET;
      sync_window   <= '0;
      locked        <= 1'b0;
      current_field <= '0;
      byte_in_field <= '0;
      partial_value <= '0;
    end else begin
      if (cfg_we) begin
        sync_pattern <= cfg_wdata;
      end
      sync_window   <= sync_window_next;
      locked        <= locked_next;
      current_field <= current_field_next;
      byte_in_field <= byte_in_field_next;
      partial_value <= partial_value_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vsfp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsfp_fifo
// Short request queue between field assembly and result output.
// ----------------------------------------------------------------------------
module vsfp_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  vsfp_pkg::field_req_t    push_req,
  input  wire logic               pop,
  output vsfp_pkg::field_req_t    pop_req,
  output logic                    full,
  output logic                    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vsfp_pkg::field_req_t entries [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_req = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vsfp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsfp_back
// Result stage: pops field requests, tags them and holds the output register.
// ----------------------------------------------------------------------------
module vsfp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  vsfp_pkg::field_req_t    q_req,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              field_index,
  output logic [31:0]             field_value,
  output logic                    half_width,
  output logic                    record_complete,
  output logic                    frame_end
);

  logic load;

  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      field_index     <= q_req.index;
      field_value     <= q_req.value;
      half_width      <= q_req.half;
      record_complete <= (q_req.index == vsfp_pkg::MOTION_FIELD);
      frame_end       <= (q_req.index == vsfp_pkg::LAST_FIELD);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vital_sign_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vital_sign_frame_parser
// Magic word synchronized parser for a fixed 46-field vital sign frame.
// ----------------------------------------------------------------------------
// Input channel: rx_byte with in_valid / in_stall, one byte per request.
// Output channel: one request per completed field (field_index, field_value,
//   half_width, record_complete, frame_end) with out_valid / out_stall.
// Config: cfg_we writes cfg_wdata into the 64-bit magic word; first received
//   byte sits in bits 7:0. Write only while the parser is idle.
// Throughput: one byte per cycle while in_stall is low, set by the field assembler.
// Path: a field's last byte is written into the queue, and the result stage
//   then loads it into the output register once out_stall allows.
// Receiver stall: the output register holds; the queue of FIFO_DEPTH entries
//   fills and in_stall rises when it is full.
// Reset: magic word returns to its default, the parser hunts, queue and
//   output are empty.
// ----------------------------------------------------------------------------
module vital_sign_frame_parser #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       field_index,
  output logic [31:0]      field_value,
  output logic             half_width,
  output logic             record_complete,
  output logic             frame_end
);

  vsfp_pkg::field_req_t push_req;
  vsfp_pkg::field_req_t pop_req;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  vsfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (push_req)
  );

  vsfp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (push_req),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  vsfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_req           (pop_req),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .field_index     (field_index),
    .field_value     (field_value),
    .half_width      (half_width),
    .record_complete (record_complete),
    .frame_end       (frame_end)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("field request pushed into a full queue");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_half_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && half_width) |-> (field_value[31:16] == 16'd0))
    else $error("half-width field carries upper bits");

  a_frame_end_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (field_index == vsfp_pkg::LAST_FIELD))
    else $error("frame end flagged on a field other than the last");
`endif

endmodule
`default_nettype wire
